@@ design/lfd_pkg.sv @@
// shared constants, types and reference table for the letter frequency deviation block
package lfd_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int LETTERS             = 26;
    localparam int LETTER_W            = 5;
    localparam int SHARE_W             = 14;
    localparam int DIFF_W              = 15;
    localparam int THR_W               = 14;
    localparam int SCALE               = 10000;
    localparam int THRESHOLD_RESET     = 500;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef logic [SHARE_W-1:0] share_t;
    typedef logic signed [DIFF_W-1:0] diff_t;

    // english reference share per letter, hundredths of a percent
    function automatic share_t ref_share(input logic [LETTER_W-1:0] idx);
        share_t r;
        case (idx)
            5'd0:    r = 14'd812;
            5'd1:    r = 14'd149;
            5'd2:    r = 14'd271;
            5'd3:    r = 14'd432;
            5'd4:    r = 14'd1202;
            5'd5:    r = 14'd230;
            5'd6:    r = 14'd203;
            5'd7:    r = 14'd592;
            5'd8:    r = 14'd731;
            5'd9:    r = 14'd10;
            5'd10:   r = 14'd69;
            5'd11:   r = 14'd398;
            5'd12:   r = 14'd261;
            5'd13:   r = 14'd695;
            5'd14:   r = 14'd768;
            5'd15:   r = 14'd182;
            5'd16:   r = 14'd11;
            5'd17:   r = 14'd602;
            5'd18:   r = 14'd628;
            5'd19:   r = 14'd910;
            5'd20:   r = 14'd288;
            5'd21:   r = 14'd111;
            5'd22:   r = 14'd209;
            5'd23:   r = 14'd17;
            5'd24:   r = 14'd211;
            5'd25:   r = 14'd7;
            default: r = 14'd0;
        endcase
        return r;
    endfunction

    // ascii punctuation ranges
    function automatic logic is_punct(input logic [7:0] c);
        return ((c >= 8'h21) && (c <= 8'h2F)) || ((c >= 8'h3A) && (c <= 8'h40)) ||
               ((c >= 8'h5B) && (c <= 8'h60)) || ((c >= 8'h7B) && (c <= 8'h7E));
    endfunction

endpackage

@@ design/lfd_ram.sv @@
// generic single write port ram with registered read
module lfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 26
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/lfd_divider.sv @@
// restoring divider, one quotient bit per cycle
module lfd_divider #(
    parameter int DEN_WIDTH = lfd_pkg::COUNT_WIDTH_DEFAULT,
    parameter int QUO_WIDTH = lfd_pkg::SHARE_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [DEN_WIDTH+QUO_WIDTH-1:0] numerator,
    input  logic [DEN_WIDTH-1:0]           denominator,
    output logic                           done,
    output logic [QUO_WIDTH-1:0]           quotient
);

    localparam int NUM_WIDTH  = DEN_WIDTH + QUO_WIDTH;
    localparam int STEP_WIDTH = $clog2(QUO_WIDTH);

    logic [NUM_WIDTH-1:0]  rem_reg;
    logic [NUM_WIDTH-1:0]  rem_next;
    logic [NUM_WIDTH-1:0]  dsh_reg;
    logic [NUM_WIDTH-1:0]  dsh_next;
    logic [QUO_WIDTH-1:0]  quo_reg;
    logic [QUO_WIDTH-1:0]  quo_next;
    logic [STEP_WIDTH-1:0] step_reg;
    logic [STEP_WIDTH-1:0] step_next;
    logic                  run_reg;
    logic                  run_next;
    logic                  done_reg;
    logic                  done_next;
    logic                  fits;

    assign fits = rem_reg >= dsh_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = numerator;
            dsh_next  = NUM_WIDTH'(denominator) << (QUO_WIDTH - 1);
            quo_next  = '0;
            step_next = STEP_WIDTH'(QUO_WIDTH - 1);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? (rem_reg - dsh_reg) : rem_reg;
            quo_next = {quo_reg[QUO_WIDTH-2:0], fits};
            dsh_next = dsh_reg >> 1;
            if (step_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ design/letter_frequency_deviation_top.sv @@
// letter frequency deviation top level: counts letters per text, reports 26 shares
// counting: one character per cycle, busy stays low, read-modify-write of the count ram
// report: after the last character busy rises; per letter the count is read, scaled,
// divided by the total in the bit-serial divider and compared with the reference share
// busy stays high until the last letter is done; results are single-cycle strobes, no stall
// reset: async, clears totals, count valid bits, state; threshold returns to 500
module letter_frequency_deviation_top #(
    parameter int COUNT_WIDTH = lfd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [7:0]                          char_code,
    input  logic                                last_char,
    input  logic                                cfg_we,
    input  logic [lfd_pkg::THR_W-1:0]           deviation_threshold,
    output logic                                result_valid,
    output logic [lfd_pkg::LETTER_W-1:0]        letter_index,
    output logic [lfd_pkg::SHARE_W-1:0]         share,
    output logic signed [lfd_pkg::DIFF_W-1:0]   difference,
    output logic                                beyond_threshold,
    output logic                                last_result
);

    localparam int LW = lfd_pkg::LETTER_W;
    localparam int SW = lfd_pkg::SHARE_W;
    localparam int DW = lfd_pkg::DIFF_W;
    localparam int NW = COUNT_WIDTH + SW;
    localparam int NL = lfd_pkg::LETTERS;

    localparam logic [2:0] ST_CNT   = 3'd0;
    localparam logic [2:0] ST_DRAIN = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_START = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [LW-1:0]          LAST_K    = LW'(NL - 1);

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [LW-1:0]           k_reg;
    logic [LW-1:0]           k_next;
    logic [COUNT_WIDTH-1:0]  total_reg;
    logic [COUNT_WIDTH-1:0]  total_next;
    logic [NL-1:0]           valid_reg;
    logic [NL-1:0]           valid_next;
    logic [lfd_pkg::THR_W-1:0] thr_reg;

    logic                    s1_valid_reg;
    logic [LW-1:0]           s1_idx_reg;
    logic                    s2_valid_reg;
    logic [LW-1:0]           s2_idx_reg;
    logic [COUNT_WIDTH-1:0]  s2_data_reg;

    logic [NW-1:0]           prod_reg;
    logic                    res_valid_reg;
    logic [LW-1:0]           res_idx_reg;
    lfd_pkg::share_t         res_share_reg;
    lfd_pkg::diff_t          res_diff_reg;
    logic                    res_beyond_reg;
    logic                    res_last_reg;

    logic                    accept;
    logic [7:0]              folded;
    logic                    is_letter;
    logic                    is_kept;
    logic [LW-1:0]           char_idx;
    logic [LW-1:0]           raddr;
    logic [COUNT_WIDTH-1:0]  rdata;
    logic [COUNT_WIDTH-1:0]  base;
    logic [COUNT_WIDTH-1:0]  bumped;
    logic [COUNT_WIDTH-1:0]  cnt_rd;
    logic                    div_done;
    logic [SW-1:0]           div_q;
    lfd_pkg::share_t         fin_share;
    lfd_pkg::diff_t          fin_diff;
    lfd_pkg::diff_t          fin_mag;
    logic                    fin_beyond;

    assign busy   = state_reg != ST_CNT;
    assign accept = start && !busy;

    // character decode
    always_comb
    begin
        folded = char_code;
        if ((char_code >= lfd_pkg::CHAR_UPPER_A) && (char_code <= lfd_pkg::CHAR_UPPER_Z))
        begin
            folded = char_code + lfd_pkg::CASE_OFFSET;
        end
        is_letter = (folded >= lfd_pkg::CHAR_LOWER_A) && (folded <= lfd_pkg::CHAR_LOWER_Z);
        char_idx  = LW'(folded - lfd_pkg::CHAR_LOWER_A);
        is_kept   = (char_code != lfd_pkg::CHAR_SPACE) && !lfd_pkg::is_punct(char_code);
    end

    assign raddr = (state_reg == ST_CNT) ? (is_letter ? char_idx : '0) : k_reg;

    lfd_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NL)
    ) u_count_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_idx_reg),
        .wdata (bumped),
        .raddr (raddr),
        .rdata (rdata)
    );

    // forward the write that coincided with this read
    always_comb
    begin
        if (s2_valid_reg && (s2_idx_reg == s1_idx_reg))
        begin
            base = s2_data_reg;
        end
        else if (valid_reg[s1_idx_reg])
        begin
            base = rdata;
        end
        else
        begin
            base = '0;
        end
        bumped = (base == COUNT_MAX) ? base : (base + 1'b1);
        cnt_rd = valid_reg[k_reg] ? rdata : '0;
    end

    lfd_divider #(
        .DEN_WIDTH (COUNT_WIDTH),
        .QUO_WIDTH (SW)
    ) u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (state_reg == ST_START),
        .numerator   (prod_reg),
        .denominator (total_reg),
        .done        (div_done),
        .quotient    (div_q)
    );

    // result arithmetic
    always_comb
    begin
        fin_share  = (total_reg == '0) ? '0 : div_q;
        fin_diff   = $signed({1'b0, fin_share}) - $signed({1'b0, lfd_pkg::ref_share(k_reg)});
        fin_mag    = fin_diff[DW-1] ? -fin_diff : fin_diff;
        fin_beyond = (total_reg != '0) && (fin_mag > $signed({1'b0, thr_reg}));
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        total_next = total_reg;
        valid_next = valid_reg;
        if (s1_valid_reg)
        begin
            valid_next[s1_idx_reg] = 1'b1;
        end
        case (state_reg)
            ST_CNT:
            begin
                if (accept)
                begin
                    if (is_kept && (total_reg != COUNT_MAX))
                    begin
                        total_next = total_reg + 1'b1;
                    end
                    if (last_char)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                k_next     = '0;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (k_reg == LAST_K)
                begin
                    total_next = '0;
                    valid_next = '0;
                    state_next = ST_CNT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            default:
            begin
                state_next = ST_CNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CNT;
            k_reg         <= '0;
            total_reg     <= '0;
            valid_reg     <= '0;
            thr_reg       <= lfd_pkg::THR_W'(lfd_pkg::THRESHOLD_RESET);
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            total_reg     <= total_next;
            valid_reg     <= valid_next;
            s1_valid_reg  <= accept && is_letter;
            s2_valid_reg  <= s1_valid_reg;
            res_valid_reg <= state_reg == ST_FIN;
            if (cfg_we)
            begin
                thr_reg <= deviation_threshold;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= char_idx;
        s2_idx_reg  <= s1_idx_reg;
        s2_data_reg <= bumped;
        if (state_reg == ST_MUL)
        begin
            prod_reg <= NW'(cnt_rd) * NW'(lfd_pkg::SCALE);
        end
        if (state_reg == ST_FIN)
        begin
            res_idx_reg    <= k_reg;
            res_share_reg  <= fin_share;
            res_diff_reg   <= fin_diff;
            res_beyond_reg <= fin_beyond;
            res_last_reg   <= k_reg == LAST_K;
        end
    end

    assign result_valid     = res_valid_reg;
    assign letter_index     = res_idx_reg;
    assign share            = res_share_reg;
    assign difference       = res_diff_reg;
    assign beyond_threshold = res_beyond_reg;
    assign last_result      = res_last_reg;

    a_last_enters_report: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_char |=> busy)
        else $error("report did not start after final transaction");

    a_share_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> share <= SW'(lfd_pkg::SCALE))
        else $error("share above full scale");

    a_last_is_z: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_result |-> letter_index == LAST_K)
        else $error("last result not on letter z");

    a_no_write_in_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CNT) && (state_reg != ST_DRAIN) |-> !s1_valid_reg)
        else $error("count write during report");

    a_busy_until_z: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_result |-> busy)
        else $error("busy dropped before report end");

endmodule
